### rtl/sfd_pkg.sv
// Shared types and constants for the stereo feedback delay.
// Holds the word layouts, store geometry, register codes and fixed multipliers.
// No dependencies.
package sfd_pkg;

    localparam int ADDR_W     = 17;
    localparam int FRAC_W     = 8;
    localparam int DEPTH      = 2 ** ADDR_W;
    localparam int POS_W      = ADDR_W + FRAC_W;
    localparam int DELAY_W    = 25;
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 15;
    localparam int Q15_W      = 16;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DELAY_W;

    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int XC_W  = 19;
    localparam int QC_W  = 15;
    localparam int DQ_W  = 20;

    localparam logic [DELAY_W-1:0] DELAY_MIN   = DELAY_W'(1 << FRAC_W);
    localparam logic [DELAY_W-1:0] DELAY_MAX   = DELAY_W'((DEPTH - 1) << FRAC_W);
    localparam logic [GAIN_W-1:0]  GAIN_MAX    = GAIN_W'(32112);
    localparam logic [Q15_W-1:0]   UNITY_Q15   = Q15_W'(32768);

    localparam logic signed [MUL_B_W-1:0] RECIP10    = MUL_B_W'(52429);
    localparam int                        RECIP10_SH = 19;
    localparam logic signed [MUL_B_W-1:0] RECIP25    = MUL_B_W'(83886);
    localparam int                        RECIP25_SH = 21;

    localparam logic signed [PROD_W-1:0] RND8  = PROD_W'(1 << (FRAC_W - 1));
    localparam logic signed [PROD_W-1:0] RND15 = PROD_W'(16384);

    localparam logic [MODE_W-1:0] MODE_MONO   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STEREO = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PING   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WET_MIX  = 3'd5;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
    } sfd_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } sfd_out_t;

endpackage

### rtl/stereo_feedback_delay.sv
// Stereo feedback delay with damping: sequencer, shared multiplier, two sample stores.
// Depends on sfd_pkg for word types, geometry and register codes.
//
// Usage:
//   in_valid/in_ready/in_data carry one stereo input word; out_valid/out_ready/out_data
//   carry one processed word back for each input word, in order.
//   cfg_we/cfg_index/cfg_data write one register per cycle, no wait; write only while idle.
//   Enabled, a sequencer of 19 steps computes each word and drives one shared
//   signed 26x18 multiplier for the damping coefficient, the right delay, two interpolations,
//   two damping updates, two feedback scalings and two mix scalings; each store has a single
//   read port, so its two neighbor reads take separate steps, ST_RD_A and then ST_RD_B.
//   Disabled, a word passes through unchanged.
//   The result sits in an output register; the next input word is accepted and processed
//   while it waits, and the sequencer holds in its last step while out_ready stays low.
//   Reset sets the config and sequencer registers to defaults, then a clearing pass writes
//   zero to every entry of both stores, one entry per cycle; in_ready stays low throughout,
//   config writes are taken.
module stereo_feedback_delay (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  sfd_pkg::sfd_in_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output sfd_pkg::sfd_out_t                 out_data,
    input  logic                              cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sfd_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MUL_C, ST_MUL_D, ST_FIX_D, ST_DR, ST_POS, ST_RD_A, ST_RD_B,
        ST_CAP_B, ST_INT_L, ST_INT_R, ST_CAP_IR, ST_DAMP_L, ST_DAMP_R, ST_CAP_DR,
        ST_FB_L, ST_FB_R, ST_MIX_L, ST_MIX_R, ST_FIN, ST_DONE
    } state_t;

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [19:0] x);
        logic signed [SAMPLE_W-1:0] r;
        if (x > 20'sd32767)
            r = 16'sh7FFF;
        else if (x < -20'sd32768)
            r = 16'sh8000;
        else
            r = x[SAMPLE_W-1:0];
        return r;
    endfunction

    state_t                      state_reg;
    logic                        enable_reg;
    logic [MODE_W-1:0]           mode_reg;
    logic [DELAY_W-1:0]          delay_reg;
    logic [GAIN_W-1:0]           gain_reg;
    logic [Q15_W-1:0]            damping_reg;
    logic [Q15_W-1:0]            wet_mix_reg;

    logic [ADDR_W-1:0]           wr_idx_reg;
    logic signed [SAMPLE_W-1:0]  damp_l_reg;
    logic signed [SAMPLE_W-1:0]  damp_r_reg;
    logic                        clr_active_reg;
    logic [ADDR_W-1:0]           clr_addr_reg;
    logic                        out_valid_reg;
    sfd_out_t                    out_data_reg;

    logic signed [SAMPLE_W-1:0]  dry_l_reg;
    logic signed [SAMPLE_W-1:0]  dry_r_reg;
    logic [Q15_W-1:0]            c_reg;
    logic [DQ_W-1:0]             dq_reg;
    logic [DELAY_W-1:0]          dr_reg;
    logic [POS_W-1:0]            pos_l_reg;
    logic [POS_W-1:0]            pos_r_reg;
    logic signed [SAMPLE_W-1:0]  a_l_reg;
    logic signed [SAMPLE_W-1:0]  a_r_reg;
    logic signed [SAMPLE_W:0]    diff_l_reg;
    logic signed [SAMPLE_W:0]    diff_r_reg;
    logic signed [SAMPLE_W-1:0]  ls_val_reg;
    logic signed [SAMPLE_W-1:0]  rs_val_reg;
    logic signed [SAMPLE_W-1:0]  res_l_reg;
    logic signed [SAMPLE_W-1:0]  res_r_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [SAMPLE_W-1:0]  rd_l_reg;
    logic signed [SAMPLE_W-1:0]  rd_r_reg;

    logic [SAMPLE_W-1:0]         left_mem  [DEPTH];
    logic [SAMPLE_W-1:0]         right_mem [DEPTH];

    logic                        is_mono;
    logic                        in_fire;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic [XC_W-1:0]             xc;
    logic [XC_W-1:0]             qc10;
    logic [QC_W-1:0]             qc;
    logic [QC_W-1:0]             qc_fix;
    logic [DELAY_W:0]            t_sum;
    logic [DELAY_W-1:0]          t_half;
    logic [DQ_W-1:0]             q0;
    logic [DELAY_W-1:0]          q0_25;
    logic [DELAY_W-1:0]          r25;
    logic [DELAY_W:0]            d2;
    logic signed [PROD_W-1:0]    rnd8_full;
    logic signed [PROD_W-1:0]    rnd15_full;
    logic signed [SAMPLE_W-1:0]  wet_l;
    logic signed [SAMPLE_W-1:0]  wet_r;
    logic signed [SAMPLE_W:0]    avg_sum;
    logic signed [SAMPLE_W-1:0]  base_l;
    logic signed [19:0]          sum_base;
    logic signed [19:0]          sum20;
    logic signed [SAMPLE_W-1:0]  sat_val;
    logic [ADDR_W-1:0]           rd_addr_l;
    logic [ADDR_W-1:0]           rd_addr_r;
    logic                        lw_en;
    logic                        rw_en;
    logic [ADDR_W-1:0]           w_addr;
    logic [SAMPLE_W-1:0]         w_data;

    assign in_ready  = (state_reg == ST_IDLE) && !clr_active_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign is_mono = (mode_reg != MODE_STEREO) && (mode_reg != MODE_PING);

    assign xc     = {damping_reg, 3'b000} + XC_W'(damping_reg) + XC_W'(5);
    assign qc     = prod_reg[RECIP10_SH +: QC_W];
    assign qc10   = {1'b0, qc, 3'b000} + {3'b000, qc, 1'b0};
    assign qc_fix = (qc10 > xc) ? qc - 1'b1 : qc;

    assign t_sum  = {1'b0, delay_reg} + (DELAY_W + 1)'(25);
    assign t_half = t_sum[DELAY_W:1];
    assign q0     = prod_reg[RECIP25_SH +: DQ_W];
    assign q0_25  = {1'b0, q0, 4'b0000} + {2'b00, q0, 3'b000} + DELAY_W'(q0);
    assign r25    = t_half - q0_25;
    assign d2     = {1'b0, delay_reg} + (DELAY_W + 1)'(dq_reg);

    assign rnd8_full  = (prod_reg + RND8) >>> FRAC_W;
    assign rnd15_full = (prod_reg + RND15) >>> 15;

    assign wet_l = (mode_reg == MODE_PING) ? rs_val_reg : ls_val_reg;
    assign wet_r = (mode_reg == MODE_PING || is_mono) ? ls_val_reg : rs_val_reg;

    assign avg_sum = (SAMPLE_W + 1)'(dry_l_reg) + (SAMPLE_W + 1)'(dry_r_reg);
    assign base_l  = is_mono ? avg_sum[SAMPLE_W:1] : dry_l_reg;

    always_comb
    begin
        unique case (state_reg)
            ST_FB_R:  sum_base = 20'(base_l);
            ST_MIX_R: sum_base = 20'(dry_l_reg);
            default:  sum_base = 20'(dry_r_reg);
        endcase
    end

    assign sum20   = sum_base + $signed(rnd15_full[19:0]);
    assign sat_val = sat16(sum20);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_C:
            begin
                mul_a = MUL_A_W'(xc);
                mul_b = RECIP10;
            end
            ST_MUL_D:
            begin
                mul_a = MUL_A_W'(t_half);
                mul_b = RECIP25;
            end
            ST_INT_L:
            begin
                mul_a = MUL_A_W'(diff_l_reg);
                mul_b = MUL_B_W'(pos_l_reg[FRAC_W-1:0]);
            end
            ST_INT_R:
            begin
                mul_a = MUL_A_W'(diff_r_reg);
                mul_b = MUL_B_W'(pos_r_reg[FRAC_W-1:0]);
            end
            ST_DAMP_L:
            begin
                mul_a = MUL_A_W'(wet_l) - MUL_A_W'(damp_l_reg);
                mul_b = MUL_B_W'(c_reg);
            end
            ST_DAMP_R:
            begin
                mul_a = MUL_A_W'(wet_r) - MUL_A_W'(damp_r_reg);
                mul_b = MUL_B_W'(c_reg);
            end
            ST_FB_L:
            begin
                mul_a = MUL_A_W'((mode_reg == MODE_PING) ? damp_r_reg : damp_l_reg);
                mul_b = MUL_B_W'(gain_reg);
            end
            ST_FB_R:
            begin
                mul_a = MUL_A_W'((mode_reg == MODE_PING) ? damp_l_reg : damp_r_reg);
                mul_b = MUL_B_W'(gain_reg);
            end
            ST_MIX_L:
            begin
                mul_a = MUL_A_W'(wet_l) - MUL_A_W'(dry_l_reg);
                mul_b = MUL_B_W'(wet_mix_reg);
            end
            ST_MIX_R:
            begin
                mul_a = MUL_A_W'(wet_r) - MUL_A_W'(dry_r_reg);
                mul_b = MUL_B_W'(wet_mix_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        rd_addr_l = pos_l_reg[POS_W-1:FRAC_W];
        rd_addr_r = pos_r_reg[POS_W-1:FRAC_W];
        if (state_reg == ST_RD_B)
        begin
            rd_addr_l = pos_l_reg[POS_W-1:FRAC_W] + 1'b1;
            rd_addr_r = pos_r_reg[POS_W-1:FRAC_W] + 1'b1;
        end
    end

    assign lw_en  = clr_active_reg || (state_reg == ST_FB_R);
    assign rw_en  = clr_active_reg || ((state_reg == ST_MIX_L) && !is_mono);
    assign w_addr = clr_active_reg ? clr_addr_reg : wr_idx_reg;
    assign w_data = clr_active_reg ? '0 : sat_val;

    always_ff @(posedge clk)
    begin
        if (lw_en)
            left_mem[w_addr] <= w_data;
        rd_l_reg <= $signed(left_mem[rd_addr_l]);
    end

    always_ff @(posedge clk)
    begin
        if (rw_en)
            right_mem[w_addr] <= w_data;
        rd_r_reg <= $signed(right_mem[rd_addr_r]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            mode_reg    <= MODE_MONO;
            delay_reg   <= DELAY_MIN;
            gain_reg    <= '0;
            damping_reg <= '0;
            wet_mix_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENABLE:   enable_reg <= cfg_data[0];
                REG_MODE:     mode_reg   <= cfg_data[MODE_W-1:0];
                REG_DELAY:
                begin
                    if (cfg_data < DELAY_MIN)
                        delay_reg <= DELAY_MIN;
                    else if (cfg_data > DELAY_MAX)
                        delay_reg <= DELAY_MAX;
                    else
                        delay_reg <= cfg_data;
                end
                REG_FEEDBACK:
                    gain_reg <= (cfg_data[GAIN_W-1:0] > GAIN_MAX) ? GAIN_MAX
                                                                  : cfg_data[GAIN_W-1:0];
                REG_DAMPING:
                    damping_reg <= (cfg_data[Q15_W-1:0] > UNITY_Q15) ? UNITY_Q15
                                                                     : cfg_data[Q15_W-1:0];
                REG_WET_MIX:
                    wet_mix_reg <= (cfg_data[Q15_W-1:0] > UNITY_Q15) ? UNITY_Q15
                                                                     : cfg_data[Q15_W-1:0];
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (in_fire)
        begin
            dry_l_reg <= in_data.left_in;
            dry_r_reg <= in_data.right_in;
        end
        unique case (state_reg)
            ST_MUL_D:  c_reg  <= UNITY_Q15 - Q15_W'(qc_fix);
            ST_FIX_D:  dq_reg <= (r25 >= DELAY_W'(25)) ? q0 + 1'b1 : q0;
            ST_DR:
            begin
                if (mode_reg != MODE_STEREO)
                    dr_reg <= delay_reg;
                else if (d2 > (DELAY_W + 1)'(DELAY_MAX))
                    dr_reg <= DELAY_MAX;
                else
                    dr_reg <= d2[DELAY_W-1:0];
            end
            ST_POS:
            begin
                pos_l_reg <= {wr_idx_reg, {FRAC_W{1'b0}}} - delay_reg;
                pos_r_reg <= {wr_idx_reg, {FRAC_W{1'b0}}} - dr_reg;
            end
            ST_RD_B:
            begin
                a_l_reg <= rd_l_reg;
                a_r_reg <= rd_r_reg;
            end
            ST_CAP_B:
            begin
                diff_l_reg <= (SAMPLE_W + 1)'(rd_l_reg) - (SAMPLE_W + 1)'(a_l_reg);
                diff_r_reg <= (SAMPLE_W + 1)'(rd_r_reg) - (SAMPLE_W + 1)'(a_r_reg);
            end
            ST_INT_R:  ls_val_reg <= a_l_reg + $signed(rnd8_full[SAMPLE_W-1:0]);
            ST_CAP_IR: rs_val_reg <= a_r_reg + $signed(rnd8_full[SAMPLE_W-1:0]);
            ST_MIX_R:  res_l_reg  <= sat_val;
            ST_FIN:    res_r_reg  <= sat_val;
            ST_IDLE:
            begin
                if (in_fire && !enable_reg)
                begin
                    res_l_reg <= in_data.left_in;
                    res_r_reg <= in_data.right_in;
                end
            end
            default: ;
        endcase
    end

    // sequencer, delay state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wr_idx_reg     <= '0;
            damp_l_reg     <= '0;
            damp_r_reg     <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                    clr_active_reg <= 1'b0;
            end
            if (out_valid_reg && out_ready && (state_reg != ST_DONE))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                        state_reg <= enable_reg ? ST_MUL_C : ST_DONE;
                end
                ST_MUL_C:  state_reg <= ST_MUL_D;
                ST_MUL_D:  state_reg <= ST_FIX_D;
                ST_FIX_D:  state_reg <= ST_DR;
                ST_DR:     state_reg <= ST_POS;
                ST_POS:    state_reg <= ST_RD_A;
                ST_RD_A:   state_reg <= ST_RD_B;
                ST_RD_B:   state_reg <= ST_CAP_B;
                ST_CAP_B:  state_reg <= ST_INT_L;
                ST_INT_L:  state_reg <= ST_INT_R;
                ST_INT_R:  state_reg <= ST_CAP_IR;
                ST_CAP_IR: state_reg <= ST_DAMP_L;
                ST_DAMP_L: state_reg <= ST_DAMP_R;
                ST_DAMP_R:
                begin
                    damp_l_reg <= damp_l_reg + $signed(rnd15_full[SAMPLE_W-1:0]);
                    state_reg  <= ST_CAP_DR;
                end
                ST_CAP_DR:
                begin
                    if (!is_mono)
                        damp_r_reg <= damp_r_reg + $signed(rnd15_full[SAMPLE_W-1:0]);
                    state_reg <= ST_FB_L;
                end
                ST_FB_L:   state_reg <= ST_FB_R;
                ST_FB_R:   state_reg <= ST_MIX_L;
                ST_MIX_L:  state_reg <= ST_MIX_R;
                ST_MIX_R:  state_reg <= ST_FIN;
                ST_FIN:
                begin
                    wr_idx_reg <= wr_idx_reg + 1'b1;
                    state_reg  <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg          <= 1'b1;
                        out_data_reg.left_out  <= res_l_reg;
                        out_data_reg.right_out <= res_r_reg;
                        state_reg              <= ST_IDLE;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
